[rtl/pmmp_pkg.sv]
package pmmp_pkg;

	localparam int MAG_W = 11;
	localparam int DIV_STEPS = MAG_W;
	localparam int CNT_W = 4;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_SNIPER = 3'd1;
	localparam logic [2:0] MODE_SCROLL = 3'd2;

	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90 = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam logic [2:0] CFG_ORIENTATION = 3'd0;
	localparam logic [2:0] CFG_ACCEL_ENABLE = 3'd1;
	localparam logic [2:0] CFG_INVERT_WHEEL = 3'd2;
	localparam logic [2:0] CFG_SNIPER_DIVISOR = 3'd3;
	localparam logic [2:0] CFG_SCROLL_DIVISOR = 3'd4;
	localparam logic [2:0] CFG_TEXT_DIVISOR = 3'd5;

	localparam logic [7:0] WHEEL_LIMIT = 8'd127;

	typedef struct packed {
		logic [2:0] mode;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic signed [7:0] wheel_v;
		logic signed [7:0] wheel_h;
		logic [7:0] buttons;
	} report_t;

	typedef struct packed {
		logic signed [11:0] out_x;
		logic signed [11:0] out_y;
		logic signed [7:0] out_v;
		logic signed [7:0] out_h;
		logic signed [11:0] tap_x;
		logic signed [11:0] tap_y;
		logic [7:0] buttons_out;
		logic mouse_active;
	} result_t;

	typedef struct packed {
		logic [1:0] orientation;
		logic accel_enable;
		logic invert_wheel;
		logic [7:0] sniper_divisor;
		logic [7:0] scroll_divisor;
		logic [7:0] text_divisor;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCEL,
		ST_SUM,
		ST_DIV,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic accel;
		logic sum;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic normal;
	} dp_status_t;

endpackage

[rtl/pmmp_ctrl.sv]
module pmmp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 report_valid,
	output logic                 report_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  pmmp_pkg::dp_status_t status,
	output pmmp_pkg::dp_cmd_t    cmd
);

	pmmp_pkg::ctrl_state_t state_q, state_d;
	logic [pmmp_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic can_load;

	assign can_load = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign report_stall = (state_q != pmmp_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmmp_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sum) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			pmmp_pkg::ST_IDLE: begin
				if (report_valid) begin
					cmd.load = 1'b1;
					state_d = pmmp_pkg::ST_ACCEL;
				end
			end
			pmmp_pkg::ST_ACCEL: begin
				cmd.accel = 1'b1;
				state_d = pmmp_pkg::ST_SUM;
			end
			pmmp_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = status.normal ? pmmp_pkg::ST_FINISH : pmmp_pkg::ST_DIV;
			end
			pmmp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == pmmp_pkg::CNT_W'(pmmp_pkg::DIV_STEPS - 1)) begin
					state_d = pmmp_pkg::ST_FINISH;
				end
			end
			pmmp_pkg::ST_FINISH: begin
				if (can_load) begin
					cmd.finish = 1'b1;
					state_d = pmmp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pmmp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/pmmp_datapath.sv]
module pmmp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pmmp_pkg::cfg_t       cfg,
	input  pmmp_pkg::dp_cmd_t    cmd,
	input  pmmp_pkg::report_t    report,
	output pmmp_pkg::dp_status_t status,
	output pmmp_pkg::result_t    result
);

	localparam int MW = pmmp_pkg::MAG_W;

	logic [2:0] mode_q;
	logic normal_q;
	logic [7:0] buttons_q;
	logic active_q;
	logic signed [8:0] xr_q, yr_q;
	logic signed [11:0] xa_q, ya_q;
	logic signed [11:0] rem_h_q, rem_v_q;
	logic neg_h_q, neg_v_q;
	logic [MW-1:0] quo_h_q, quo_v_q;
	logic [7:0] par_h_q, par_v_q;
	logic [7:0] divisor_q;
	pmmp_pkg::result_t result_q;

	logic wheel_any;
	logic signed [7:0] src_x, src_y;
	logic signed [8:0] ex, ey, rx, ry;
	logic [2:0] mode_eff;
	logic active;

	logic signed [11:0] sum_h, sum_v;
	logic [MW-1:0] mag_h, mag_v;
	logic [7:0] dsel, dnext;

	logic [8:0] sh_h, sh_v;
	logic bit_h, bit_v;

	logic [11:0] qh_s, qv_s, rh_s, rv_s;
	logic [MW-1:0] qmh, qmv;
	logic snap, kill_h, kill_v, any_q;
	logic [7:0] hmag, vmag;
	logic signed [11:0] rem_h_d, rem_v_d;
	pmmp_pkg::result_t res;

	function automatic logic [11:0] accel_val(input logic [8:0] v, input logic en);
		logic [8:0] m;
		logic [17:0] sq;
		logic [11:0] a;
		m = v[8] ? 9'(~v + 9'd1) : v;
		sq = 18'(m) * 18'(m);
		a = en ? 12'(sq >> 4) + 12'(m) : 12'(m);
		return v[8] ? 12'(12'd0 - a) : a;
	endfunction

	function automatic logic [7:0] sat_mag(input logic [MW-1:0] q);
		return (q > MW'(pmmp_pkg::WHEEL_LIMIT)) ? pmmp_pkg::WHEEL_LIMIT : q[7:0];
	endfunction

	assign status.normal = normal_q;
	assign result = result_q;

	always_comb begin
		wheel_any = (report.wheel_v != 8'sd0) || (report.wheel_h != 8'sd0);
		src_x = wheel_any ? report.wheel_h : report.dx;
		src_y = wheel_any ? report.wheel_v : report.dy;
		ex = {src_x[7], src_x};
		ey = {src_y[7], src_y};
		unique case (cfg.orientation)
			pmmp_pkg::ROT_90: begin
				rx = -ey;
				ry = ex;
			end
			pmmp_pkg::ROT_180: begin
				rx = -ex;
				ry = -ey;
			end
			pmmp_pkg::ROT_270: begin
				rx = ey;
				ry = -ex;
			end
			default: begin
				rx = ex;
				ry = ey;
			end
		endcase
		mode_eff = wheel_any ? pmmp_pkg::MODE_SCROLL : report.mode;
		active = wheel_any || (report.dx != 8'sd0) || (report.dy != 8'sd0)
			|| (report.buttons != 8'd0);
	end

	always_comb begin
		sum_h = rem_h_q + xa_q;
		sum_v = rem_v_q + ya_q;
		mag_h = sum_h[11] ? MW'(-sum_h) : MW'(sum_h);
		mag_v = sum_v[11] ? MW'(-sum_v) : MW'(sum_v);
		if (mode_q == pmmp_pkg::MODE_SNIPER) begin
			dsel = cfg.sniper_divisor;
		end else if (mode_q == pmmp_pkg::MODE_SCROLL) begin
			dsel = cfg.scroll_divisor;
		end else begin
			dsel = cfg.text_divisor;
		end
		dnext = (dsel == 8'd0) ? 8'd1 : dsel;
	end

	always_comb begin
		sh_h = {par_h_q, quo_h_q[MW-1]};
		sh_v = {par_v_q, quo_v_q[MW-1]};
		bit_h = (sh_h >= {1'b0, divisor_q});
		bit_v = (sh_v >= {1'b0, divisor_q});
	end

	always_comb begin
		qh_s = neg_h_q ? 12'(12'd0 - 12'(quo_h_q)) : 12'(quo_h_q);
		qv_s = neg_v_q ? 12'(12'd0 - 12'(quo_v_q)) : 12'(quo_v_q);
		rh_s = neg_h_q ? 12'(12'd0 - 12'(par_h_q)) : 12'(par_h_q);
		rv_s = neg_v_q ? 12'(12'd0 - 12'(par_v_q)) : 12'(par_v_q);
		any_q = (quo_h_q != '0) || (quo_v_q != '0);
		snap = (mode_q != pmmp_pkg::MODE_SNIPER);
		kill_v = snap && (quo_h_q > quo_v_q);
		kill_h = snap && (quo_h_q < quo_v_q);
		qmh = kill_h ? '0 : quo_h_q;
		qmv = kill_v ? '0 : quo_v_q;
		hmag = sat_mag(qmh);
		vmag = sat_mag(qmv);

		res = '0;
		res.buttons_out = buttons_q;
		res.mouse_active = active_q;
		if (normal_q) begin
			rem_h_d = '0;
			rem_v_d = '0;
			res.out_x = xa_q;
			res.out_y = ya_q;
		end else begin
			rem_h_d = kill_h ? 12'sd0 : $signed(rh_s);
			rem_v_d = kill_v ? 12'sd0 : $signed(rv_s);
			if (any_q) begin
				case (mode_q)
					pmmp_pkg::MODE_SNIPER: begin
						res.out_x = $signed(qh_s);
						res.out_y = $signed(qv_s);
					end
					pmmp_pkg::MODE_SCROLL: begin
						res.out_h = (neg_h_q ^ cfg.invert_wheel) ?
							$signed(8'(8'd0 - hmag)) : $signed(hmag);
						res.out_v = (!neg_v_q ^ cfg.invert_wheel) ?
							$signed(8'(8'd0 - vmag)) : $signed(vmag);
					end
					default: begin
						res.tap_x = neg_h_q ? $signed(12'(12'd0 - 12'(qmh))) :
							$signed(12'(qmh));
						res.tap_y = neg_v_q ? $signed(12'(12'd0 - 12'(qmv))) :
							$signed(12'(qmv));
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_h_q <= '0;
			rem_v_q <= '0;
		end else if (cmd.finish) begin
			rem_h_q <= rem_h_d;
			rem_v_q <= rem_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_eff;
			normal_q <= (mode_eff == pmmp_pkg::MODE_NORMAL);
			buttons_q <= report.buttons;
			active_q <= active;
			xr_q <= rx;
			yr_q <= ry;
		end
		if (cmd.accel) begin
			xa_q <= $signed(accel_val(xr_q, cfg.accel_enable));
			ya_q <= $signed(accel_val(yr_q, cfg.accel_enable));
		end
		if (cmd.sum) begin
			neg_h_q <= sum_h[11];
			neg_v_q <= sum_v[11];
			quo_h_q <= mag_h;
			quo_v_q <= mag_v;
			par_h_q <= '0;
			par_v_q <= '0;
			divisor_q <= dnext;
		end
		if (cmd.div_step) begin
			quo_h_q <= {quo_h_q[MW-2:0], bit_h};
			quo_v_q <= {quo_v_q[MW-2:0], bit_v};
			par_h_q <= bit_h ? 8'(sh_h - {1'b0, divisor_q}) : sh_h[7:0];
			par_v_q <= bit_v ? 8'(sh_v - {1'b0, divisor_q}) : sh_v[7:0];
		end
		if (cmd.finish) begin
			result_q <= res;
		end
	end

endmodule

[rtl/pointer_motion_mode_processor_top.sv]
// Pointer report shaper. A report word enters on report/report_valid and is
// taken at an edge where report_valid is high and report_stall is low. One
// result word leaves on result/result_valid for every report, in order.
// The controller handles one report at a time: rotation is applied as the
// report is taken, then it applies acceleration, then the remainder add,
// then, in the divided modes only, steps the restoring divider (one quotient
// bit per cycle for both axes at once, on a shared divisor and step count),
// and then loads the output register. The next report can be taken on the
// cycle after the result is loaded. The output register holds the result
// while result_stall is high, and a new report is taken meanwhile; if its
// result is ready before the old one leaves, the controller waits with the
// new result until the register frees. Reset clears both remainders, the
// output valid flag and all configuration registers to their defaults
// (divisors 2, 16 and 32). The configuration port writes one register per
// cycle with cfg_we and should only be used while no report is in flight.
module pointer_motion_mode_processor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                report_valid,
	output logic                report_stall,
	input  pmmp_pkg::report_t   report,
	output logic                result_valid,
	input  logic                result_stall,
	output pmmp_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	pmmp_pkg::cfg_t cfg_q;
	pmmp_pkg::dp_cmd_t cmd;
	pmmp_pkg::dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation <= pmmp_pkg::ROT_NONE;
			cfg_q.accel_enable <= 1'b0;
			cfg_q.invert_wheel <= 1'b0;
			cfg_q.sniper_divisor <= 8'd2;
			cfg_q.scroll_divisor <= 8'd16;
			cfg_q.text_divisor <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pmmp_pkg::CFG_ORIENTATION: cfg_q.orientation <= cfg_data[1:0];
				pmmp_pkg::CFG_ACCEL_ENABLE: cfg_q.accel_enable <= cfg_data[0];
				pmmp_pkg::CFG_INVERT_WHEEL: cfg_q.invert_wheel <= cfg_data[0];
				pmmp_pkg::CFG_SNIPER_DIVISOR: cfg_q.sniper_divisor <= cfg_data;
				pmmp_pkg::CFG_SCROLL_DIVISOR: cfg_q.scroll_divisor <= cfg_data;
				pmmp_pkg::CFG_TEXT_DIVISOR: cfg_q.text_divisor <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pmmp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	pmmp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.report (report),
		.status (status),
		.result (result)
	);

endmodule

[tb/pointer_motion_mode_processor_top_tb.sv]
`timescale 1ns / 1ps

module pointer_motion_mode_processor_top_tb;

	localparam logic [2:0] MODE_TEXT = 3'd3;
	localparam logic [2:0] MODE_USER_A = 3'd4;
	localparam logic [2:0] MODE_USER_B = 3'd5;
	localparam logic [2:0] MODE_USER_C = 3'd6;
	localparam logic [2:0] MODE_SEVEN = 3'd7;
	localparam int ACCEL_DIV = 16;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 200000;

	class report_shaper_scoreboard;
		pmmp_pkg::cfg_t settings;
		int rem_h;
		int rem_v;
		pmmp_pkg::result_t expected_words[$];
		int mismatches;

		function new();
			settings = '{pmmp_pkg::ROT_NONE, 1'b0, 1'b0, 8'd2, 8'd16, 8'd32};
			rem_h = 0;
			rem_v = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] data);
			case (idx)
				pmmp_pkg::CFG_ORIENTATION: settings.orientation = data[1:0];
				pmmp_pkg::CFG_ACCEL_ENABLE: settings.accel_enable = data[0];
				pmmp_pkg::CFG_INVERT_WHEEL: settings.invert_wheel = data[0];
				pmmp_pkg::CFG_SNIPER_DIVISOR: settings.sniper_divisor = data;
				pmmp_pkg::CFG_SCROLL_DIVISOR: settings.scroll_divisor = data;
				pmmp_pkg::CFG_TEXT_DIVISOR: settings.text_divisor = data;
				default: ;
			endcase
		endfunction

		function int boosted(int v);
			int sq;
			sq = (v * v) / ACCEL_DIV;
			return (v > 0) ? sq + v : v - sq;
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		function int clip_wheel(int v);
			if (v > int'(pmmp_pkg::WHEEL_LIMIT))
				return int'(pmmp_pkg::WHEEL_LIMIT);
			if (v < -int'(pmmp_pkg::WHEEL_LIMIT))
				return -int'(pmmp_pkg::WHEEL_LIMIT);
			return v;
		endfunction

		function void shape_report(pmmp_pkg::report_t word);
			pmmp_pkg::result_t w;
			logic [2:0] m;
			logic [7:0] d;
			int x, y, wv, wh, t, dvs, sx, sy, ox, oy, ov, oh, tx, ty;
			m = word.mode;
			x = $signed(word.dx);
			y = $signed(word.dy);
			wv = $signed(word.wheel_v);
			wh = $signed(word.wheel_h);
			ox = 0;
			oy = 0;
			ov = 0;
			oh = 0;
			tx = 0;
			ty = 0;
			if (wv != 0 || wh != 0) begin
				m = pmmp_pkg::MODE_SCROLL;
				x = wh;
				y = wv;
			end
			case (settings.orientation)
				pmmp_pkg::ROT_90: begin
					t = x;
					x = -y;
					y = t;
				end
				pmmp_pkg::ROT_180: begin
					x = -x;
					y = -y;
				end
				pmmp_pkg::ROT_270: begin
					t = x;
					x = y;
					y = -t;
				end
				default: ;
			endcase
			if (settings.accel_enable) begin
				x = boosted(x);
				y = boosted(y);
			end
			if (m == pmmp_pkg::MODE_NORMAL) begin
				rem_h = 0;
				rem_v = 0;
				ox = x;
				oy = y;
			end else begin
				d = (m == pmmp_pkg::MODE_SNIPER) ? settings.sniper_divisor :
					(m == pmmp_pkg::MODE_SCROLL) ? settings.scroll_divisor :
					settings.text_divisor;
				dvs = (d == 8'd0) ? 1 : int'(d);
				rem_h += x;
				rem_v += y;
				sx = rem_h / dvs;
				sy = rem_v / dvs;
				rem_h -= sx * dvs;
				rem_v -= sy * dvs;
				if (sx != 0 || sy != 0) begin
					if (m == pmmp_pkg::MODE_SNIPER) begin
						ox = sx;
						oy = sy;
					end else begin
						if (magnitude(sx) > magnitude(sy)) begin
							sy = 0;
							rem_v = 0;
						end else if (magnitude(sx) < magnitude(sy)) begin
							sx = 0;
							rem_h = 0;
						end
						if (m == pmmp_pkg::MODE_SCROLL) begin
							oh = clip_wheel(sx);
							ov = clip_wheel(-sy);
							if (settings.invert_wheel) begin
								oh = -oh;
								ov = -ov;
							end
						end else begin
							tx = sx;
							ty = sy;
						end
					end
				end
			end
			w.out_x = 12'(ox);
			w.out_y = 12'(oy);
			w.out_v = 8'(ov);
			w.out_h = 8'(oh);
			w.tap_x = 12'(tx);
			w.tap_y = 12'(ty);
			w.buttons_out = word.buttons;
			w.mouse_active = (word.dx != 0 || word.dy != 0 || word.wheel_v != 0 ||
				word.wheel_h != 0 || word.buttons != 0);
			expected_words.push_back(w);
		endfunction

		function void compare_field(string field, logic [11:0] want, logic [11:0] seen);
			if (seen !== want) begin
				if (mismatches < 10)
					$display("mismatch on %s: expected %h, got %h", field, want, seen);
				mismatches++;
			end
		endfunction

		function void check_word(pmmp_pkg::result_t seen);
			pmmp_pkg::result_t want;
			if (expected_words.size() == 0) begin
				if (mismatches < 10)
					$display("result word with no report pending: %h", seen);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("out_x", want.out_x, seen.out_x);
			compare_field("out_y", want.out_y, seen.out_y);
			compare_field("out_v", want.out_v, seen.out_v);
			compare_field("out_h", want.out_h, seen.out_h);
			compare_field("tap_x", want.tap_x, seen.tap_x);
			compare_field("tap_y", want.tap_y, seen.tap_y);
			compare_field("buttons_out", want.buttons_out, seen.buttons_out);
			compare_field("mouse_active", want.mouse_active, seen.mouse_active);
		endfunction

		function int waiting();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic report_valid = 1'b0;
	logic report_stall;
	pmmp_pkg::report_t report = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	pmmp_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = pmmp_pkg::CFG_ORIENTATION;
	logic [7:0] cfg_data = 8'd0;
	bit no_idle = 1'b0;
	report_shaper_scoreboard sb;

	pointer_motion_mode_processor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.report(report),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic pmmp_pkg::report_t make_report(logic [2:0] mode, logic [7:0] dx,
		logic [7:0] dy, logic [7:0] wv, logic [7:0] wh, logic [7:0] btn);
		pmmp_pkg::report_t r;
		r.mode = mode;
		r.dx = dx;
		r.dy = dy;
		r.wheel_v = wv;
		r.wheel_h = wh;
		r.buttons = btn;
		return r;
	endfunction

	function automatic logic [7:0] pick_motion();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 8'h80 : 8'h7f;
			1, 2: return 8'($urandom_range(0, 255));
			default: return 8'(int'($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	task automatic send_report(input pmmp_pkg::report_t word);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			report_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		report_valid <= 1'b1;
		report <= word;
		@(posedge clk);
		while (report_stall)
			@(posedge clk);
		sb.shape_report(word);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic load_settings(input pmmp_pkg::cfg_t s);
		report_valid <= 1'b0;
		while (sb.waiting() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		put_reg(pmmp_pkg::CFG_ORIENTATION, {6'd0, s.orientation});
		put_reg(pmmp_pkg::CFG_ACCEL_ENABLE, {7'd0, s.accel_enable});
		put_reg(pmmp_pkg::CFG_INVERT_WHEEL, {7'd0, s.invert_wheel});
		put_reg(pmmp_pkg::CFG_SNIPER_DIVISOR, s.sniper_divisor);
		put_reg(pmmp_pkg::CFG_SCROLL_DIVISOR, s.scroll_divisor);
		put_reg(pmmp_pkg::CFG_TEXT_DIVISOR, s.text_divisor);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 8);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			sb.check_word(result);
			@(negedge clk);
		end
	end

	initial begin
		pmmp_pkg::cfg_t s;
		logic [2:0] run_mode;
		logic [2:0] m;
		int run_len;
		int n;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_report(make_report(pmmp_pkg::MODE_NORMAL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_NORMAL, 8'h7f, 8'h80, 8'd0, 8'd0, 8'hff));
		send_report(make_report(pmmp_pkg::MODE_SNIPER, 8'd5, -8'sd5, 8'd0, 8'd0, 8'h01));
		send_report(make_report(pmmp_pkg::MODE_SNIPER, 8'h80, 8'h7f, 8'd0, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_SCROLL, 8'd40, 8'd3, 8'd0, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_NORMAL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_SCROLL, 8'd32, -8'sd32, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_TEXT, 8'd100, -8'sd30, 8'd0, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_NORMAL, 8'd1, 8'd1, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_TEXT, 8'd32, -8'sd32, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_USER_A, -8'sd70, 8'd90, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_USER_B, 8'h7f, 8'h7f, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_USER_C, 8'h80, 8'h80, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_SEVEN, 8'd64, -8'sd100, 8'd0, 8'd0, 8'h00));
		send_report(make_report(MODE_SEVEN, 8'h80, 8'd5, 8'd0, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_NORMAL, 8'd9, 8'd9, 8'h7f, 8'd0, 8'h00));
		send_report(make_report(MODE_TEXT, 8'd0, 8'd0, 8'h80, 8'h80, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_SNIPER, 8'd0, 8'd0, 8'd0, 8'h7f, 8'h55));
		send_report(make_report(pmmp_pkg::MODE_SCROLL, 8'd0, 8'd0, 8'd1, 8'd0, 8'h00));
		send_report(make_report(pmmp_pkg::MODE_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h80));
		send_report(make_report(MODE_SEVEN, 8'd0, 8'd0, 8'hff, 8'd64, 8'haa));

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				case (p)
					1: s = '{pmmp_pkg::ROT_90, 1'b1, 1'b1, 8'd1, 8'd1, 8'd1};
					2: s = '{pmmp_pkg::ROT_180, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255};
					3: s = '{pmmp_pkg::ROT_270, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0};
					4: s = '{pmmp_pkg::ROT_NONE, 1'b1, 1'b1, 8'd3, 8'd200, 8'd7};
					default: begin
						s.orientation = 2'($urandom_range(0, 3));
						s.accel_enable = 1'($urandom_range(0, 1));
						s.invert_wheel = 1'($urandom_range(0, 1));
						s.sniper_divisor = 8'($urandom_range(0, $urandom_range(0, 1) ? 255 : 40));
						s.scroll_divisor = 8'($urandom_range(0, $urandom_range(0, 1) ? 255 : 40));
						s.text_divisor = 8'($urandom_range(0, $urandom_range(0, 1) ? 255 : 40));
					end
				endcase
				load_settings(s);
			end
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				run_mode = 3'($urandom_range(0, 7));
				run_len = $urandom_range(1, 12);
				no_idle = ($urandom_range(0, 4) == 0);
				for (int k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
					m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : run_mode;
					send_report(make_report(m, pick_motion(), pick_motion(),
						($urandom_range(0, 3) == 0) ? pick_motion() : 8'd0,
						($urandom_range(0, 3) == 0) ? pick_motion() : 8'd0,
						$urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'h00));
					n++;
				end
			end
		end
		report_valid <= 1'b0;
		no_idle = 1'b0;

		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.waiting() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
rtl/pmmp_pkg.sv
rtl/pmmp_ctrl.sv
rtl/pmmp_datapath.sv
rtl/pointer_motion_mode_processor_top.sv
tb/pointer_motion_mode_processor_top_tb.sv
